/* hdl/lfre_pkg.sv */
package lfre_pkg;

  localparam int FUNC_W     = 2;
  localparam int CHAN_W     = 3;
  localparam int VAL_W      = 16;
  localparam int CNT_W      = 16;
  localparam int STEP_W     = 16;
  localparam int PROD_W     = CNT_W + VAL_W;
  localparam int DIV_CNT_W  = $clog2(PROD_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0]  CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONST_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL  = 2'd2;

  localparam logic [STEP_W-1:0] FADE_STEPS_RST = 16'd40;
  localparam logic [VAL_W-1:0]  MAX_LEVEL_RST  = 16'd100;

  typedef enum logic [FUNC_W-1:0] {
    FN_SET  = 2'd0,
    FN_JUMP = 2'd1,
    FN_STOP = 2'd2,
    FN_TICK = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_START,
    S_DIV,
    S_ADD,
    S_WB,
    S_OUT
  } state_e;

endpackage

/* hdl/lfre_if.sv */
interface lfre_in_if import lfre_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CHAN_W-1:0] channel;
  logic [VAL_W-1:0]  value;

  modport source (output valid, func, channel, value, input ready);
  modport sink   (input valid, func, channel, value, output ready);
endinterface

interface lfre_out_if import lfre_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_channel;
  logic [VAL_W-1:0]  level;
  logic [VAL_W-1:0]  target;
  logic              changed;
  logic              fading;
  logic              rising;

  modport source (output valid, out_channel, level, target, changed, fading, rising,
                  input ready);
  modport sink   (input valid, out_channel, level, target, changed, fading, rising,
                  output ready);
endinterface

/* hdl/lfre_div.sv */
module lfre_div import lfre_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] dividend_i,
  input  logic [STEP_W-1:0] divisor_i,
  output logic              done_o,
  output logic [PROD_W-1:0] quotient_o
);

  logic [STEP_W-1:0]    rem_q, rem_d;
  logic [PROD_W-1:0]    quo_q, quo_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [STEP_W:0]      shifted;
  logic [STEP_W:0]      trial;
  logic                 fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem_q, quo_q[PROD_W-1]};
    trial   = shifted - {1'b0, divisor_i};
    fits    = shifted >= {1'b0, divisor_i};
    rem_d   = fits ? trial[STEP_W-1:0] : shifted[STEP_W-1:0];
    quo_d   = {quo_q[PROD_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(PROD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* hdl/led_fade_ramp_engine_core.sv */
// Set, jump and stop items, and ticks on a settled channel, go from the read state straight
// to output; a fading tick first passes the start, divide, add and write-back states.
// One item at a time; a new item is taken once the previous result is loaded into the
// output register, which waits while the output still holds an unaccepted result.
// Reset: asynchronous, active low; channel state reads as zero through per-entry valid bits,
// registers return to fade_steps 40, const_time 0, max_level 100.
module led_fade_ramp_engine_core import lfre_pkg::*; #(
  parameter int CHANNELS   = 8,
  parameter int LEVEL_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lfre_in_if.sink               in_i,
  lfre_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EXT_W = PROD_W + 2;
  localparam logic [VAL_W-1:0] LEVEL_MAX = VAL_W'((32'd1 << LEVEL_BITS) - 32'd1);
  localparam logic [6:0]       CH_LIM    = 7'(CHANNELS);

  typedef struct packed {
    logic [LEVEL_BITS-1:0] tgt;
    logic [LEVEL_BITS-1:0] cur;
    logic [LEVEL_BITS-1:0] st;
    logic [CNT_W-1:0]      cnt;
  } entry_t;

  state_e state_q, state_d;

  // configuration
  logic [STEP_W-1:0] fade_steps_q;
  logic              const_time_q;
  logic [VAL_W-1:0]  max_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_steps_q <= FADE_STEPS_RST;
      const_time_q <= 1'b0;
      max_level_q  <= MAX_LEVEL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FADE_STEPS: fade_steps_q <= cfg_data_i[STEP_W-1:0];
        CFG_CONST_TIME: const_time_q <= cfg_data_i[0];
        CFG_MAX_LEVEL:  max_level_q  <= cfg_data_i[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // item registers
  func_e             func_q;
  logic [CHAN_W-1:0] chan_q;
  logic [VAL_W-1:0]  val_q;
  logic              oor;
  logic              in_take;

  assign in_take = in_i.valid && in_i.ready;
  assign oor     = 7'(chan_q) >= CH_LIM;

  // channel state memory
  entry_t             mem_q [CHANNELS];
  entry_t             rd_data_q;
  logic               rd_valid_q;
  logic [CHANNELS-1:0] valid_q;
  logic [CH_AW-1:0]   rd_idx, wr_idx;
  logic               mem_we;
  entry_t             wr_data;
  entry_t             ent;

  assign rd_idx = CH_AW'(in_i.channel);
  assign wr_idx = CH_AW'(chan_q);
  assign ent    = rd_valid_q ? rd_data_q : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_idx] <= wr_data;
    end
    rd_data_q <= mem_q[rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_q[wr_idx] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_idx];
    end
  end

  // set, jump and stop update straight from the read entry
  entry_t           upd;
  logic [VAL_W-1:0] lim, valc, jmp, tgt16, cur16, st16;

  always_comb begin
    logic restart;
    restart = 1'b0;
    tgt16   = VAL_W'(ent.tgt);
    cur16   = VAL_W'(ent.cur);
    st16    = VAL_W'(ent.st);
    lim     = (max_level_q < LEVEL_MAX) ? max_level_q : LEVEL_MAX;
    valc    = (val_q > lim) ? lim : val_q;
    jmp     = (val_q > LEVEL_MAX) ? LEVEL_MAX : val_q;
    upd     = ent;
    unique case (func_q)
      FN_SET: begin
        if (val_q != tgt16) begin
          if (cur16 != tgt16) begin
            if (!const_time_q) begin
              // same direction beyond the current level: retarget only
              if ((st16 < tgt16 && cur16 < valc) || (st16 > tgt16 && cur16 > valc)) begin
                upd.tgt = LEVEL_BITS'(valc);
              end else begin
                restart = 1'b1;
              end
            end
          end else begin
            restart = 1'b1;
          end
        end
        if (restart) begin
          upd.tgt = LEVEL_BITS'(valc);
          upd.st  = ent.cur;
          upd.cnt = CNT_W'(1);
        end
      end
      FN_JUMP: begin
        upd.tgt = LEVEL_BITS'(jmp);
        upd.cur = LEVEL_BITS'(jmp);
      end
      FN_STOP: upd.tgt = ent.cur;
      default: ;
    endcase
  end

  // tick preparation: direction and span magnitude
  logic              tick_idle, tick_rising, tick_neg;
  logic [VAL_W:0]    diff_up, diff, span;
  logic [VAL_W-1:0]  span_mag;

  always_comb begin
    tick_idle   = ent.cur == ent.tgt;
    tick_rising = ent.cur < ent.tgt;
    diff_up     = {1'b0, tgt16} - {1'b0, st16};
    diff        = tick_rising ? diff_up : (~diff_up + 1'b1);
    span        = const_time_q ? diff : {1'b0, max_level_q};
    tick_neg    = span[VAL_W];
    span_mag    = tick_neg ? VAL_W'(~span + 1'b1) : span[VAL_W-1:0];
  end

  entry_t           ent_q;
  logic             rising_q, add_q;
  logic [VAL_W-1:0] mag_q;

  // multiply, then divide by the step count
  logic [PROD_W-1:0] prod, quo;
  logic [STEP_W-1:0] steps_eff;
  logic              div_start, div_done;

  assign prod      = PROD_W'(ent_q.cnt) * PROD_W'(mag_q);
  assign steps_eff = (fade_steps_q == '0) ? STEP_W'(1) : fade_steps_q;
  assign div_start = state_q == S_START;

  lfre_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod),
    .divisor_i  (steps_eff),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  logic signed [EXT_W-1:0] nv_q, st_ext, q_ext, tgt_ext, cur_ext, clamp;
  logic                    moved;
  logic [LEVEL_BITS-1:0]   new_cur;
  entry_t                  wb_entry;

  always_comb begin
    st_ext  = $signed({{(EXT_W-LEVEL_BITS){1'b0}}, ent_q.st});
    q_ext   = $signed({2'b00, quo});
    tgt_ext = $signed({{(EXT_W-LEVEL_BITS){1'b0}}, ent_q.tgt});
    cur_ext = $signed({{(EXT_W-LEVEL_BITS){1'b0}}, ent_q.cur});
    // never step past the target, never step away from it
    if (rising_q) begin
      clamp = (nv_q > tgt_ext) ? tgt_ext : nv_q;
      moved = clamp > cur_ext;
    end else begin
      clamp = (nv_q < tgt_ext) ? tgt_ext : nv_q;
      moved = clamp < cur_ext;
    end
    new_cur      = moved ? clamp[LEVEL_BITS-1:0] : ent_q.cur;
    wb_entry     = ent_q;
    wb_entry.cur = new_cur;
    wb_entry.cnt = (ent_q.cnt == CNT_MAX) ? ent_q.cnt : ent_q.cnt + 1'b1;
  end

  assign wr_data = (state_q == S_WB) ? wb_entry : upd;

  // result and output registers
  logic [LEVEL_BITS-1:0] res_level_q, res_target_q;
  logic                  res_changed_q;
  logic                  out_valid_q, out_load, out_free;

  assign out_free = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_i.valid) state_d = S_READ;
      S_READ:  state_d = (!oor && func_q == FN_TICK && !tick_idle) ? S_START : S_OUT;
      S_START: state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_ADD;
      S_ADD:   state_d = S_WB;
      S_WB:    state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_i.ready = 1'b0;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE:  in_i.ready = 1'b1;
      S_READ:  mem_we = !oor && func_q != FN_TICK;
      S_WB:    mem_we = 1'b1;
      S_OUT:   out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q <= func_e'(in_i.func);
      chan_q <= in_i.channel;
      val_q  <= in_i.value;
    end
    unique case (state_q)
      S_READ: begin
        ent_q    <= ent;
        rising_q <= tick_rising;
        add_q    <= tick_rising ^ tick_neg;
        mag_q    <= span_mag;
        if (oor) begin
          res_level_q   <= '0;
          res_target_q  <= '0;
          res_changed_q <= 1'b0;
        end else begin
          res_level_q   <= upd.cur;
          res_target_q  <= upd.tgt;
          res_changed_q <= func_q == FN_JUMP;
        end
      end
      S_ADD: nv_q <= add_q ? (st_ext + q_ext) : (st_ext - q_ext);
      S_WB: begin
        res_level_q   <= new_cur;
        res_target_q  <= ent_q.tgt;
        res_changed_q <= moved;
      end
      default: ;
    endcase
    if (out_load) begin
      out_o.out_channel <= chan_q;
      out_o.level       <= VAL_W'(res_level_q);
      out_o.target      <= VAL_W'(res_target_q);
      out_o.changed     <= res_changed_q;
      out_o.fading      <= res_level_q != res_target_q;
      out_o.rising      <= res_level_q < res_target_q;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import lfre_pkg::*;

  localparam int NUM_CH = 8;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [VAL_W-1:0]  level;
    logic [VAL_W-1:0]  target;
    logic              changed;
    logic              fading;
    logic              rising;
  } fade_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  lfre_in_if  in_if ();
  lfre_out_if out_if ();

  led_fade_ramp_engine_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Fade state and register copies kept by the predictor
  logic [VAL_W-1:0] tgt_lvl   [NUM_CH];
  logic [VAL_W-1:0] cur_lvl   [NUM_CH];
  logic [VAL_W-1:0] start_lvl [NUM_CH];
  logic [CNT_W-1:0] step_cnt  [NUM_CH];
  logic [STEP_W-1:0] fade_steps_cfg;
  logic              const_time_cfg;
  logic [VAL_W-1:0]  max_level_cfg;

  fade_result_t expected_levels_q[$];
  int unsigned  mismatch_cnt = 0;
  int unsigned  src_idle_pct;
  int unsigned  snk_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic fade_result_t apply_fade_item(func_e f, logic [CHAN_W-1:0] ch,
                                                   logic [VAL_W-1:0] v);
    fade_result_t r;
    logic [VAL_W-1:0] clamped;
    longint t, c, s, n, steps, span, nv;
    logic moved;
    r = '0;
    moved = 1'b0;
    r.chan = ch;
    case (f)
      FN_SET: begin
        if (v != tgt_lvl[ch]) begin
          clamped = (v > max_level_cfg) ? max_level_cfg : v;
          // ignore while fading in constant-time mode
          if (cur_lvl[ch] == tgt_lvl[ch] || !const_time_cfg) begin
            if (!(cur_lvl[ch] != tgt_lvl[ch] &&
                  ((start_lvl[ch] < tgt_lvl[ch] && cur_lvl[ch] < clamped) ||
                   (start_lvl[ch] > tgt_lvl[ch] && cur_lvl[ch] > clamped)))) begin
              step_cnt[ch]  = CNT_W'(1);
              start_lvl[ch] = cur_lvl[ch];
            end
            tgt_lvl[ch] = clamped;
          end
        end
      end
      FN_JUMP: begin
        tgt_lvl[ch] = v;
        cur_lvl[ch] = v;
        r.changed   = 1'b1;
      end
      FN_STOP: begin
        tgt_lvl[ch] = cur_lvl[ch];
      end
      default: begin
        if (cur_lvl[ch] != tgt_lvl[ch]) begin
          t = longint'(tgt_lvl[ch]);
          c = longint'(cur_lvl[ch]);
          s = longint'(start_lvl[ch]);
          n = longint'(step_cnt[ch]);
          steps = (fade_steps_cfg == '0) ? longint'(1) : longint'(fade_steps_cfg);
          if (c < t) begin
            if (const_time_cfg) span = t - s;
            else span = longint'(max_level_cfg);
            nv = s + (n * span) / steps;
            if (nv > t) nv = t;
            moved = (nv > c);
          end else begin
            if (const_time_cfg) span = s - t;
            else span = longint'(max_level_cfg);
            nv = s - (n * span) / steps;
            if (nv < t) nv = t;
            moved = (nv < c);
          end
          if (moved) cur_lvl[ch] = nv[VAL_W-1:0];
          if (step_cnt[ch] != CNT_MAX) step_cnt[ch] = step_cnt[ch] + 1'b1;
          r.changed = moved;
        end
      end
    endcase
    r.level  = cur_lvl[ch];
    r.target = tgt_lvl[ch];
    r.fading = (cur_lvl[ch] != tgt_lvl[ch]);
    r.rising = (cur_lvl[ch] < tgt_lvl[ch]);
    return r;
  endfunction

  function automatic void compare_field(string what, logic [2:0] ch, int unsigned want,
                                        int unsigned got);
    if (want != got) begin
      $display("%0t: channel %0d %s expected %0d, got %0d", $time, ch, what, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin : check_results
    fade_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_levels_q.size() == 0) begin
        $display("%0t: unexpected result on channel %0d, level %0d", $time,
                 out_if.out_channel, out_if.level);
        mismatch_cnt++;
      end else begin
        want = expected_levels_q.pop_front();
        compare_field("out_channel", want.chan, 32'(want.chan), 32'(out_if.out_channel));
        compare_field("level", want.chan, 32'(want.level), 32'(out_if.level));
        compare_field("target", want.chan, 32'(want.target), 32'(out_if.target));
        compare_field("changed", want.chan, 32'(want.changed), 32'(out_if.changed));
        compare_field("fading", want.chan, 32'(want.fading), 32'(out_if.fading));
        compare_field("rising", want.chan, 32'(want.rising), 32'(out_if.rising));
      end
    end
  end

  // Hold the item until it is taken, then record what it should produce
  task automatic send_item(func_e f, logic [CHAN_W-1:0] ch, logic [VAL_W-1:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.func    <= f;
    in_if.channel <= ch;
    in_if.value   <= v;
    do @(posedge clk_i); while (!in_if.ready);
    expected_levels_q.push_back(apply_fade_item(f, ch, v));
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_levels_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic program_regs(logic [STEP_W-1:0] fs, logic ct, logic [VAL_W-1:0] ml);
    logic [CFG_IDX_W-1:0]  idx  [3];
    logic [CFG_DATA_W-1:0] vals [3];
    idx  = '{CFG_FADE_STEPS, CFG_CONST_TIME, CFG_MAX_LEVEL};
    vals = '{fs, {{(CFG_DATA_W-1){1'b0}}, ct}, ml};
    wait_idle();
    for (int i = 0; i < 3; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    fade_steps_cfg = fs;
    const_time_cfg = ct;
    max_level_cfg  = ml;
  endtask

  task automatic test_reset_defaults();
    send_item(FN_TICK, 3'd0, 16'h0000);
    send_item(FN_SET,  3'd0, 16'h0000);
    send_item(FN_JUMP, 3'd7, 16'hFFFF);
    send_item(FN_SET,  3'd7, 16'h0000);
    send_item(FN_TICK, 3'd7, 16'hAAAA);
  endtask

  task automatic test_speed_retarget();
    send_item(FN_SET,  3'd1, 16'hFFFF);
    send_item(FN_TICK, 3'd1, 16'h5555);
    send_item(FN_TICK, 3'd1, 16'h0000);
    // same direction, beyond current level: retarget only
    send_item(FN_SET,  3'd1, 16'd50);
    send_item(FN_TICK, 3'd1, 16'h0000);
    // reverse: restart from the current level
    send_item(FN_SET,  3'd1, 16'd3);
    send_item(FN_TICK, 3'd1, 16'h0000);
    send_item(FN_STOP, 3'd1, 16'hFFFF);
    send_item(FN_TICK, 3'd1, 16'h0000);
  endtask

  task automatic test_const_time();
    program_regs(16'd1, 1'b1, 16'hFFFF);
    send_item(FN_SET,  3'd2, 16'hFFFF);
    send_item(FN_SET,  3'd2, 16'd10);
    send_item(FN_TICK, 3'd2, 16'h0000);
    // zero steps behaves as one
    program_regs(16'd0, 1'b1, 16'hFFFF);
    send_item(FN_SET,  3'd3, 16'd1234);
    send_item(FN_TICK, 3'd3, 16'h0000);
  endtask

  task automatic test_backward_step();
    program_regs(FADE_STEPS_RST, 1'b0, MAX_LEVEL_RST);
    send_item(FN_SET,  3'd4, 16'd100);
    send_item(FN_TICK, 3'd4, 16'h0000);
    send_item(FN_TICK, 3'd4, 16'h0000);
    // far more steps: computed level falls behind the current one
    program_regs(16'hFFFF, 1'b0, MAX_LEVEL_RST);
    send_item(FN_TICK, 3'd4, 16'h0000);
    program_regs(FADE_STEPS_RST, 1'b0, 16'd0);
    send_item(FN_SET,  3'd5, 16'd500);
    send_item(FN_JUMP, 3'd6, 16'h0000);
  endtask

  task automatic test_random_fades(int n_items);
    int sent;
    int r;
    logic [STEP_W-1:0] fs;
    logic ct;
    logic [VAL_W-1:0] ml, v;
    logic [CHAN_W-1:0] hot, ch;
    func_e f;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0: fs = 16'd0;
        1: fs = 16'd1;
        2: fs = 16'hFFFF;
        default: fs = STEP_W'($urandom_range(48, 2));
      endcase
      ct = 1'($urandom_range(1));
      case ($urandom_range(9))
        0: ml = 16'd0;
        1: ml = 16'hFFFF;
        default: ml = VAL_W'($urandom_range(400, 1));
      endcase
      program_regs(fs, ct, ml);
      hot = CHAN_W'($urandom_range(NUM_CH - 1));
      for (int i = 0; i < 54 && sent < n_items; i++) begin
        ch = ($urandom_range(99) < 70) ? hot : CHAN_W'($urandom_range(NUM_CH - 1));
        r = $urandom_range(99);
        if (r < 55) f = FN_TICK;
        else if (r < 78) f = FN_SET;
        else if (r < 88) f = FN_JUMP;
        else f = FN_STOP;
        case ($urandom_range(9))
          0: v = 16'h0000;
          1: v = 16'hFFFF;
          2: v = tgt_lvl[ch];
          3, 4: v = VAL_W'($urandom_range(16'hFFFF));
          default: v = VAL_W'($urandom_range(ml));
        endcase
        send_item(f, ch, v);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_FADE_STEPS;
    cfg_data      = '0;
    in_if.valid   = 1'b0;
    in_if.func    = FN_SET;
    in_if.channel = '0;
    in_if.value   = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      tgt_lvl[i]   = '0;
      cur_lvl[i]   = '0;
      start_lvl[i] = '0;
      step_cnt[i]  = '0;
    end
    fade_steps_cfg = FADE_STEPS_RST;
    const_time_cfg = 1'b0;
    max_level_cfg  = MAX_LEVEL_RST;
    src_idle_pct   = 19;
    snk_idle_pct   = 66;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_speed_retarget();
    test_const_time();
    test_backward_step();
    test_random_fades(217);
    src_idle_pct = 66;
    snk_idle_pct = 19;
    test_random_fades(217);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_fades(217);

    wait_idle();
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* led_fade_ramp_engine_core.f */
hdl/lfre_pkg.sv
hdl/lfre_if.sv
hdl/lfre_div.sv
hdl/led_fade_ramp_engine_core.sv
sim/testbench.sv
